FILE: design/kmst_pkg.sv
// ----------------------------------------------------------------------------
// kmst_pkg
// Shared types, sizes and codes for the Kruskal spanning tree core.
// ----------------------------------------------------------------------------
package kmst_pkg;

  localparam int MAX_NODES  = 1024;
  localparam int MAX_EDGES  = 4096;
  localparam int NODE_W     = $clog2(MAX_NODES);        // node index
  localparam int NCNT_W     = NODE_W + 1;               // node count / set size
  localparam int EIDX_W     = $clog2(MAX_EDGES);        // edge store address
  localparam int ECNT_W     = EIDX_W + 1;               // edge count
  localparam int WGT_W      = 32;
  localparam int SUM_W      = 44;
  localparam int MULT_W     = 16;
  localparam int HALF_W     = SUM_W / 2;
  localparam int PROD_W     = SUM_W + MULT_W;
  localparam int COST_W     = 63;
  localparam int CFG_DATA_W = 16;

  typedef enum logic {
    REG_NODE_COUNT      = 1'b0,
    REG_COST_MULTIPLIER = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [NODE_W-1:0] endpoint_a;
    logic [NODE_W-1:0] endpoint_b;
    logic [WGT_W-1:0]  edge_weight;
    logic              edge_present;
    logic              last_edge;
  } in_word_t;

  typedef struct packed {
    logic              spanned;
    logic [COST_W-1:0] scaled_cost;
  } out_word_t;

  typedef struct packed {
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [WGT_W-1:0]  weight;
  } edge_rec_t;

  typedef struct packed {
    logic start;
  } mul_ctrl_t;

  typedef struct packed {
    logic done;
  } mul_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SORT_RUN,
    ST_SORT_RD,
    ST_SORT_WR,
    ST_EDGE_RD,
    ST_EDGE_CHK,
    ST_FIND_A_RD,
    ST_FIND_A_CMP,
    ST_FIND_B_RD,
    ST_FIND_B_CMP,
    ST_SIZE_RD,
    ST_JOIN,
    ST_STOP,
    ST_SCALE_GO,
    ST_SCALE,
    ST_FINISH
  } state_t;

endpackage

FILE: design/kruskal_mst_union_find_core.sv
// ----------------------------------------------------------------------------
// kruskal_mst_union_find_core
// Loads graph edges, merge sorts them by weight, runs Kruskal over a
// union-by-size disjoint-set store and reports the scaled tree weight.
// ----------------------------------------------------------------------------
//  channel | signals                        | direction
//  --------+--------------------------------+----------
//  input   | in_valid, in_stall, in_word    | edge words in
//  output  | out_valid, out_stall, out_word | one result word per graph
//  config  | cfg_write, cfg_index, cfg_data | register writes
//
// An edge word is taken every cycle while loading. A word with
// last_edge starts the run: the set store is cleared, the edges are merge
// sorted (a setup step per run, a read and a write per element moved), then
// each edge is range checked, the roots of its two ends are found by following
// parent links and the two sets are joined when the roots differ; once the tree
// spans, the weight sum is scaled, and then the result is posted.
// Reset is synchronous; the set store is cleared at the start of every run.
// in_stall stays high for the whole run; a run that ends while the previous
// result still waits in out_word holds until that word is taken.
// ----------------------------------------------------------------------------
module kruskal_mst_union_find_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  kmst_pkg::in_word_t            in_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output kmst_pkg::out_word_t           out_word,
  input  logic                          cfg_write,
  input  kmst_pkg::cfg_reg_t            cfg_index,
  input  logic [kmst_pkg::CFG_DATA_W-1:0] cfg_data
);
  import kmst_pkg::*;

  state_t state, state_next;

  // configuration
  logic [NCNT_W-1:0] node_count;
  logic [MULT_W-1:0] cost_multiplier;

  // run registers
  logic [NCNT_W-1:0] n_used;
  logic [ECNT_W-1:0] edge_count;
  logic [NCNT_W-1:0] clr_idx;
  logic              src_sel;
  logic [ECNT_W-1:0] sort_width;
  logic [ECNT_W:0]   sort_lo;
  logic [ECNT_W-1:0] sort_mid, sort_hi;
  logic [ECNT_W-1:0] sort_p, sort_q, sort_k;
  logic [NODE_W-1:0] walk, root_a, root_b;
  logic [NODE_W-1:0] joined;
  logic [SUM_W-1:0]  weight_sum;
  logic              spanned;

  // edge buffers (ping-pong), each one write and two read ports
  edge_rec_t buf0 [MAX_EDGES];
  edge_rec_t buf1 [MAX_EDGES];
  edge_rec_t rx0, ry0, rx1, ry1, rec_x, rec_y, wr_rec;
  logic [EIDX_W-1:0] addr_x, addr_y, wr_addr;
  logic              wr0, wr1;

  // disjoint-set store
  logic [NODE_W-1:0] parent_mem [MAX_NODES];
  logic [NCNT_W-1:0] size_mem   [MAX_NODES];
  logic [NODE_W-1:0] par_raddr, par_waddr, par_wdata, par_q;
  logic [NODE_W-1:0] size_waddr;
  logic [NCNT_W-1:0] size_wdata, size_qa, size_qb;
  logic              par_we, size_we;

  // scaler
  mul_ctrl_t         mul_ctrl;
  mul_stat_t         mul_stat;
  logic [PROD_W-1:0] product;

  // decoded conditions
  logic              in_take;
  logic              take_q;
  logic              sort_run_end, sort_pass_end, sort_all_end;
  logic [ECNT_W:0]   lo_step;
  logic              in_range;
  logic              reached;
  logic              last_k;
  logic [NCNT_W-1:0] size_sum;
  logic              a_bigger;

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;

  assign rec_x = src_sel ? rx1 : rx0;
  assign rec_y = src_sel ? ry1 : ry0;

  // stable merge: take the right run when the left run is used up or the right is strictly lighter
  assign take_q = (sort_p >= sort_mid) ||
                  ((sort_q < sort_hi) && (rec_y.weight < rec_x.weight));
  assign sort_run_end  = (sort_k + ECNT_W'(1)) == sort_hi;
  assign lo_step       = sort_lo + {sort_width, 1'b0};
  assign sort_pass_end = sort_run_end && (lo_step >= {1'b0, edge_count});
  assign sort_all_end  = {sort_width, 1'b0} >= {1'b0, edge_count};

  assign in_range = ({1'b0, rec_x.node_a} < n_used) && ({1'b0, rec_x.node_b} < n_used);
  assign reached  = (n_used != '0) && ({1'b0, joined} == (n_used - NCNT_W'(1)));
  assign last_k   = (sort_k + ECNT_W'(1)) == edge_count;
  assign size_sum = size_qa + size_qb;
  assign a_bigger = size_qa >= size_qb;

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_take && in_word.last_edge) state_next = ST_CLEAR;
      end
      ST_CLEAR: begin
        if (clr_idx >= n_used) begin
          if (edge_count == '0)                   state_next = ST_FINISH;
          else if (edge_count == ECNT_W'(1))      state_next = ST_EDGE_RD;
          else                                    state_next = ST_SORT_RUN;
        end
      end
      ST_SORT_RUN: state_next = ST_SORT_RD;
      ST_SORT_RD:  state_next = ST_SORT_WR;
      ST_SORT_WR: begin
        if (!sort_run_end)       state_next = ST_SORT_RD;
        else if (!sort_pass_end) state_next = ST_SORT_RUN;
        else if (sort_all_end)   state_next = ST_EDGE_RD;
        else                     state_next = ST_SORT_RUN;
      end
      ST_EDGE_RD:  state_next = ST_EDGE_CHK;
      ST_EDGE_CHK: state_next = in_range ? ST_FIND_A_RD : ST_STOP;
      ST_FIND_A_RD:  state_next = ST_FIND_A_CMP;
      ST_FIND_A_CMP: state_next = (par_q == walk) ? ST_FIND_B_RD : ST_FIND_A_RD;
      ST_FIND_B_RD:  state_next = ST_FIND_B_CMP;
      ST_FIND_B_CMP: begin
        if (par_q != walk)        state_next = ST_FIND_B_RD;
        else if (walk == root_a)  state_next = ST_STOP;
        else                      state_next = ST_SIZE_RD;
      end
      ST_SIZE_RD: state_next = ST_JOIN;
      ST_JOIN:    state_next = ST_STOP;
      ST_STOP: begin
        if (reached)      state_next = ST_SCALE_GO;
        else if (last_k)  state_next = ST_FINISH;
        else              state_next = ST_EDGE_RD;
      end
      ST_SCALE_GO: state_next = ST_SCALE;
      ST_SCALE:    state_next = mul_stat.done ? ST_FINISH : ST_SCALE;
      ST_FINISH:   state_next = (!out_valid || !out_stall) ? ST_IDLE : ST_FINISH;
      default:     state_next = ST_IDLE;
    endcase
  end

  // ------------------------------------------------------ memory port control
  always_comb begin
    addr_x     = sort_p[EIDX_W-1:0];
    addr_y     = sort_q[EIDX_W-1:0];
    wr_addr    = sort_k[EIDX_W-1:0];
    wr_rec     = take_q ? rec_y : rec_x;
    wr0        = 1'b0;
    wr1        = 1'b0;
    par_raddr  = walk;
    par_we     = 1'b0;
    par_waddr  = clr_idx[NODE_W-1:0];
    par_wdata  = clr_idx[NODE_W-1:0];
    size_we    = 1'b0;
    size_waddr = clr_idx[NODE_W-1:0];
    size_wdata = NCNT_W'(1);
    mul_ctrl.start = 1'b0;
    case (state)
      ST_IDLE: begin
        // load the arriving edge into the first buffer
        wr_addr = edge_count[EIDX_W-1:0];
        wr_rec  = '{node_a: in_word.endpoint_a, node_b: in_word.endpoint_b,
                    weight: in_word.edge_weight};
        wr0     = in_take && in_word.edge_present && (edge_count < ECNT_W'(MAX_EDGES));
      end
      ST_CLEAR: begin
        par_we  = clr_idx < n_used;
        size_we = clr_idx < n_used;
      end
      ST_SORT_WR: begin
        wr0 = src_sel;
        wr1 = !src_sel;
      end
      ST_EDGE_RD, ST_EDGE_CHK, ST_FIND_A_RD, ST_FIND_A_CMP, ST_FIND_B_RD,
      ST_FIND_B_CMP, ST_SIZE_RD, ST_STOP: begin
        // keep the current edge on the read port for the whole step
        addr_x = sort_k[EIDX_W-1:0];
      end
      ST_JOIN: begin
        addr_x     = sort_k[EIDX_W-1:0];
        par_we     = 1'b1;
        size_we    = 1'b1;
        par_waddr  = a_bigger ? root_b : root_a;
        par_wdata  = a_bigger ? root_a : root_b;
        size_waddr = a_bigger ? root_a : root_b;
        size_wdata = size_sum;
      end
      ST_SCALE_GO: mul_ctrl.start = 1'b1;
      default: ;
    endcase
  end

  // ------------------------------------------------------------------ memories
  always_ff @(posedge clk) begin
    if (wr0) buf0[wr_addr] <= wr_rec;
    rx0 <= buf0[addr_x];
    ry0 <= buf0[addr_y];
  end

  always_ff @(posedge clk) begin
    if (wr1) buf1[wr_addr] <= wr_rec;
    rx1 <= buf1[addr_x];
    ry1 <= buf1[addr_y];
  end

  always_ff @(posedge clk) begin
    if (par_we) parent_mem[par_waddr] <= par_wdata;
    par_q <= parent_mem[par_raddr];
  end

  always_ff @(posedge clk) begin
    if (size_we) size_mem[size_waddr] <= size_wdata;
    size_qa <= size_mem[root_a];
    size_qb <= size_mem[root_b];
  end

  kmst_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (mul_ctrl),
    .sum     (weight_sum),
    .mult    (cost_multiplier),
    .stat    (mul_stat),
    .product (product)
  );

  // ----------------------------------------------------------- control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      node_count      <= NCNT_W'(1);
      cost_multiplier <= MULT_W'(1);
      edge_count      <= '0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        case (cfg_index)
          REG_NODE_COUNT:      node_count      <= cfg_data[NCNT_W-1:0];
          REG_COST_MULTIPLIER: cost_multiplier <= cfg_data[MULT_W-1:0];
          default: ;
        endcase
      end
      if (wr0 && state == ST_IDLE) edge_count <= edge_count + ECNT_W'(1);
      if (state == ST_FINISH && state_next == ST_IDLE) begin
        out_valid  <= 1'b1;
        edge_count <= '0;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------ datapath regs
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        // clamp the node count and start a fresh run
        n_used     <= (node_count > NCNT_W'(MAX_NODES)) ? NCNT_W'(MAX_NODES) : node_count;
        clr_idx    <= '0;
        src_sel    <= 1'b0;
        sort_width <= ECNT_W'(1);
        sort_lo    <= '0;
        sort_k     <= '0;
        joined     <= '0;
        weight_sum <= '0;
        spanned    <= 1'b0;
      end
      ST_CLEAR: begin
        clr_idx <= clr_idx + NCNT_W'(1);
      end
      ST_SORT_RUN: begin
        sort_mid <= (sort_lo + (ECNT_W+1)'(sort_width) < {1'b0, edge_count}) ?
                    ECNT_W'(sort_lo + (ECNT_W+1)'(sort_width)) : edge_count;
        sort_hi  <= (lo_step < {1'b0, edge_count}) ? lo_step[ECNT_W-1:0] : edge_count;
        sort_p   <= sort_lo[ECNT_W-1:0];
        sort_q   <= (sort_lo + (ECNT_W+1)'(sort_width) < {1'b0, edge_count}) ?
                    ECNT_W'(sort_lo + (ECNT_W+1)'(sort_width)) : edge_count;
        sort_k   <= sort_lo[ECNT_W-1:0];
      end
      ST_SORT_WR: begin
        if (take_q) sort_q <= sort_q + ECNT_W'(1);
        else        sort_p <= sort_p + ECNT_W'(1);
        if (sort_run_end && sort_pass_end) begin
          // swap buffers and double the run length
          sort_lo    <= '0;
          src_sel    <= !src_sel;
          sort_width <= {sort_width[ECNT_W-2:0], 1'b0};
          sort_k     <= '0;
        end else begin
          sort_k <= sort_k + ECNT_W'(1);
          if (sort_run_end) sort_lo <= lo_step;
        end
      end
      ST_EDGE_CHK: begin
        walk <= rec_x.node_a;
      end
      ST_FIND_A_CMP: begin
        if (par_q == walk) begin
          root_a <= walk;
          walk   <= rec_x.node_b;
        end else begin
          walk <= par_q;
        end
      end
      ST_FIND_B_CMP: begin
        if (par_q == walk) root_b <= walk;
        else               walk   <= par_q;
      end
      ST_JOIN: begin
        joined     <= joined + NODE_W'(1);
        weight_sum <= weight_sum + SUM_W'(rec_x.weight);
      end
      ST_STOP: begin
        spanned <= reached;
        sort_k  <= sort_k + ECNT_W'(1);
      end
      default: ;
    endcase
  end

  // hold the result word until taken
  always_ff @(posedge clk) begin
    if (state == ST_FINISH && state_next == ST_IDLE) begin
      out_word.spanned     <= spanned;
      out_word.scaled_cost <= spanned ? COST_W'(product) : '0;
    end
  end

endmodule

FILE: design/kmst_mul.sv
// ----------------------------------------------------------------------------
// kmst_mul
// Two-step 22x16 multiplier: scales the 44-bit tree weight by the multiplier.
// ----------------------------------------------------------------------------
module kmst_mul (
  input  logic                     clk,
  input  logic                     rst,
  input  kmst_pkg::mul_ctrl_t      ctrl,
  input  logic [kmst_pkg::SUM_W-1:0]  sum,
  input  logic [kmst_pkg::MULT_W-1:0] mult,
  output kmst_pkg::mul_stat_t      stat,
  output logic [kmst_pkg::PROD_W-1:0] product
);
  import kmst_pkg::*;

  logic                     phase;
  logic                     done;
  logic [HALF_W+MULT_W-1:0] part;
  logic [HALF_W-1:0]        operand;
  logic [HALF_W+MULT_W-1:0] mul_out;

  // one shared multiplier: low half first, high half second
  assign operand = phase ? sum[SUM_W-1:HALF_W] : sum[HALF_W-1:0];
  assign mul_out = operand * mult;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        phase <= 1'b1;
      end else if (phase) begin
        phase <= 1'b0;
        done  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      part <= mul_out;
    end
    if (phase) begin
      product <= {mul_out, {HALF_W{1'b0}}} + PROD_W'(part);
    end
  end

  assign stat.done = done;

endmodule

FILE: design/kmst_checker.sv
// ----------------------------------------------------------------------------
// kmst_checker
// Port-level checks on the Kruskal core, bound to the top level.
// ----------------------------------------------------------------------------
module kmst_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input kmst_pkg::in_word_t  in_word,
  input logic                out_valid,
  input logic                out_stall,
  input kmst_pkg::out_word_t out_word
);
  import kmst_pkg::*;

  // a stalled result word stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_word))
    else $error("result word changed while stalled");

  // the run starts right after the final edge word
  a_run_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_word.last_edge |=> in_stall)
    else $error("input not stalled after final edge word");

  a_unspanned_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.spanned |-> out_word.scaled_cost == '0)
    else $error("cost nonzero on unspanned result");

endmodule

bind kruskal_mst_union_find_core kmst_checker u_kmst_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
